/* sv/mhs_pkg.sv */
// Shared constants, register codes and item types for the multipath hash selector.
`timescale 1ns / 1ps

package mhs_pkg;

   // Path table limits and field widths.
   localparam int MAX_PATHS       = 16;
   localparam int COUNT_WIDTH     = 5;
   localparam int INDEX_WIDTH     = 4;
   localparam int HASH_WIDTH      = 64;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int MODE_WIDTH      = 2;

   // Hash chain length and the mixing constants of splitmix64.
   localparam int          CHAIN_LENGTH = 7;
   localparam logic [63:0] GOLDEN_INC   = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;
   localparam logic [63:0] CHOICE_TAG   = 64'h0000004b53430001;

   // Remainder pipeline: digits of the dividend reduced per stage.
   localparam int MOD_DIGIT_WIDTH      = 4;
   localparam int MOD_DIGITS_PER_STAGE = 2;
   localparam int MOD_STAGES = HASH_WIDTH / (MOD_DIGIT_WIDTH * MOD_DIGITS_PER_STAGE);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HASH_SEED   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SELECT_MODE = 2'd1;

   // Selection modes; the unused code behaves as per-flow hash.
   localparam logic [MODE_WIDTH-1:0] MODE_ROUND_ROBIN = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_PACKET_HASH = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_FLOW_HASH   = 2'd2;

   // Item fields that travel alongside the hash through the pipeline.
   typedef struct packed {
      logic [15:0]            source_node;
      logic [11:0]            dest_group;
      logic [31:0]            flow_number;
      logic [31:0]            route_tag;
      logic [31:0]            packet_number;
      logic [31:0]            round_robin_count;
      logic [COUNT_WIDTH-1:0] divisor;
      logic                   use_round_robin;
      logic                   no_path;
   } side_type;

endpackage

/* sv/mhs_mix_unit.sv */
// One splitmix64 mix as a five-stage pipeline with split 64-bit multiplies.
`timescale 1ns / 1ps

module mhs_mix_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic [mhs_pkg::HASH_WIDTH-1:0] hash_in,
   input  logic [mhs_pkg::HASH_WIDTH-1:0] operand_in,
   input  mhs_pkg::side_type            side_in,
   output logic                         out_valid,
   output logic [mhs_pkg::HASH_WIDTH-1:0] hash_out,
   output mhs_pkg::side_type            side_out
);

   logic [4:0] valid_ff;
   logic [4:0] valid_in;

   mhs_pkg::side_type side1_ff, side2_ff, side3_ff, side4_ff, side5_ff;

   logic [63:0] x1_ff, x1_in;
   logic [63:0] p0a_ff, p0a_in;
   logic [31:0] p1a_ff, p1a_in, p2a_ff, p2a_in;
   logic [63:0] z3_ff, z3_in;
   logic [63:0] p0b_ff, p0b_in;
   logic [31:0] p1b_ff, p1b_in, p2b_ff, p2b_in;
   logic [63:0] w5_ff, w5_in;
   logic [63:0] sum_a, sum_b, pre_add;

   // Stage 1: fold in the operand, add the golden increment, first xorshift.
   always_comb begin
      pre_add = (hash_in ^ operand_in) + mhs_pkg::GOLDEN_INC;
      x1_in   = pre_add ^ (pre_add >> 30);
   end

   // Stage 2: partial products of the first multiply; cross terms keep the low half.
   always_comb begin
      p0a_in = 64'(x1_ff[31:0]) * 64'(mhs_pkg::MIX_MUL_A[31:0]);
      p1a_in = x1_ff[31:0] * mhs_pkg::MIX_MUL_A[63:32];
      p2a_in = x1_ff[63:32] * mhs_pkg::MIX_MUL_A[31:0];
   end

   // Stage 3: sum the first product and apply the second xorshift.
   always_comb begin
      sum_a = p0a_ff + {p1a_ff + p2a_ff, 32'b0};
      z3_in = sum_a ^ (sum_a >> 27);
   end

   // Stage 4: partial products of the second multiply.
   always_comb begin
      p0b_in = 64'(z3_ff[31:0]) * 64'(mhs_pkg::MIX_MUL_B[31:0]);
      p1b_in = z3_ff[31:0] * mhs_pkg::MIX_MUL_B[63:32];
      p2b_in = z3_ff[63:32] * mhs_pkg::MIX_MUL_B[31:0];
   end

   // Stage 5: sum the second product and apply the final xorshift.
   always_comb begin
      sum_b = p0b_ff + {p1b_ff + p2b_ff, 32'b0};
      w5_in = sum_b ^ (sum_b >> 31);
   end

   // Valid bits shift along with the data.
   assign valid_in = {valid_ff[3:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Payload registers move only when the pipeline advances.
   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff    <= x1_in;
         side1_ff <= side_in;
         p0a_ff   <= p0a_in;
         p1a_ff   <= p1a_in;
         p2a_ff   <= p2a_in;
         side2_ff <= side1_ff;
         z3_ff    <= z3_in;
         side3_ff <= side2_ff;
         p0b_ff   <= p0b_in;
         p1b_ff   <= p1b_in;
         p2b_ff   <= p2b_in;
         side4_ff <= side3_ff;
         w5_ff    <= w5_in;
         side5_ff <= side4_ff;
      end
   end

   assign out_valid = valid_ff[4];
   assign hash_out  = w5_ff;
   assign side_out  = side5_ff;

`ifndef SYNTHESIS
   // A frozen pipeline keeps its last stage unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (!advance && out_valid) |=> (out_valid && $stable(hash_out)))
      else $error("mix unit output changed while the pipeline was held");
`endif

endmodule

/* sv/mhs_mod_unit.sv */
// Pipelined remainder of a 64-bit value by a path count of one to sixteen.
`timescale 1ns / 1ps

module mhs_mod_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic [mhs_pkg::HASH_WIDTH-1:0]    dividend_in,
   input  mhs_pkg::side_type                 side_in,
   output logic                              out_valid,
   output logic [mhs_pkg::INDEX_WIDTH-1:0]   path_index,
   output logic                              no_path
);

   localparam int STEP_WIDTH  = mhs_pkg::INDEX_WIDTH + mhs_pkg::MOD_DIGIT_WIDTH + 1;
   localparam int STAGE_WIDTH = mhs_pkg::MOD_DIGIT_WIDTH * mhs_pkg::MOD_DIGITS_PER_STAGE;

   // One digit of restoring reduction: (rem * radix + digit) mod divisor, rem < divisor.
   function automatic logic [mhs_pkg::INDEX_WIDTH-1:0] mod_step(
      input logic [mhs_pkg::INDEX_WIDTH-1:0]     rem,
      input logic [mhs_pkg::MOD_DIGIT_WIDTH-1:0] digit,
      input logic [mhs_pkg::COUNT_WIDTH-1:0]     divisor
   );
      logic [STEP_WIDTH-1:0] partial;
      logic [STEP_WIDTH-1:0] shifted;
      partial = {1'b0, rem, digit};
      for (int s = mhs_pkg::MOD_DIGIT_WIDTH - 1; s >= 0; s--) begin
         shifted = STEP_WIDTH'(divisor) << s;
         if (partial >= shifted) begin
            partial = partial - shifted;
         end
      end
      return partial[mhs_pkg::INDEX_WIDTH-1:0];
   endfunction

   logic                                 valid_ff    [mhs_pkg::MOD_STAGES];
   logic [mhs_pkg::INDEX_WIDTH-1:0]      rem_ff      [mhs_pkg::MOD_STAGES];
   logic [mhs_pkg::INDEX_WIDTH-1:0]      rem_in      [mhs_pkg::MOD_STAGES];
   logic [mhs_pkg::HASH_WIDTH-1:0]       dividend_ff [mhs_pkg::MOD_STAGES];
   logic [mhs_pkg::COUNT_WIDTH-1:0]      divisor_ff  [mhs_pkg::MOD_STAGES];
   logic                                 no_path_ff  [mhs_pkg::MOD_STAGES];

   // Sources of each stage: the unit inputs for the first, the previous stage otherwise.
   logic                                 src_valid    [mhs_pkg::MOD_STAGES];
   logic [mhs_pkg::INDEX_WIDTH-1:0]      src_rem      [mhs_pkg::MOD_STAGES];
   logic [mhs_pkg::HASH_WIDTH-1:0]       src_dividend [mhs_pkg::MOD_STAGES];
   logic [mhs_pkg::COUNT_WIDTH-1:0]      src_divisor  [mhs_pkg::MOD_STAGES];
   logic                                 src_no_path  [mhs_pkg::MOD_STAGES];

   assign src_valid[0]    = in_valid;
   assign src_rem[0]      = '0;
   assign src_dividend[0] = dividend_in;
   assign src_divisor[0]  = side_in.divisor;
   assign src_no_path[0]  = side_in.no_path;

   for (genvar j = 0; j < mhs_pkg::MOD_STAGES; j++) begin : g_stage
      if (j > 0) begin : g_link
         assign src_valid[j]    = valid_ff[j-1];
         assign src_rem[j]      = rem_ff[j-1];
         assign src_dividend[j] = dividend_ff[j-1];
         assign src_divisor[j]  = divisor_ff[j-1];
         assign src_no_path[j]  = no_path_ff[j-1];
      end

      // Reduce this stage's digits, most significant first.
      always_comb begin
         logic [mhs_pkg::INDEX_WIDTH-1:0] acc;
         acc = src_rem[j];
         for (int d = 0; d < mhs_pkg::MOD_DIGITS_PER_STAGE; d++) begin
            acc = mod_step(acc,
               src_dividend[j][mhs_pkg::HASH_WIDTH - 1 - j * STAGE_WIDTH
                               - d * mhs_pkg::MOD_DIGIT_WIDTH -: mhs_pkg::MOD_DIGIT_WIDTH],
               src_divisor[j]);
         end
         rem_in[j] = acc;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (advance) begin
            valid_ff[j] <= src_valid[j];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j]      <= rem_in[j];
            dividend_ff[j] <= src_dividend[j];
            divisor_ff[j]  <= src_divisor[j];
            no_path_ff[j]  <= src_no_path[j];
         end
      end
   end

   assign out_valid  = valid_ff[mhs_pkg::MOD_STAGES-1];
   assign path_index = rem_ff[mhs_pkg::MOD_STAGES-1];
   assign no_path    = no_path_ff[mhs_pkg::MOD_STAGES-1];

`ifndef SYNTHESIS
   // The remainder always lies below its divisor.
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> ({1'b0, path_index} < divisor_ff[mhs_pkg::MOD_STAGES-1]))
      else $error("remainder not below the path count");

   // An item without paths divides by one and so leaves index zero.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && no_path) |-> (path_index == '0))
      else $error("no-path item carries a nonzero index");

   // Entering items never carry a zero divisor.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid && advance) |-> (side_in.divisor != '0))
      else $error("zero divisor entered the remainder pipeline");
`endif

endmodule

/* sv/multipath_hash_selector_top.sv */
// Top level of the multipath hash selector: config registers, hash chain and remainder.
`timescale 1ns / 1ps

// The selector takes one item per clock while results are taken and returns one result
// per item, in order. The pipeline is made of the seven splitmix64 mix units of five
// register stages each (every 64-bit multiply is split into 32-bit partial products over
// two stages) followed by the eight-stage remainder pipeline, which reduces two hex digits
// of the dividend per stage. When the result is not taken the whole pipeline holds, and
// req_ready falls in the same cycle. Round robin items travel the same path so that results
// stay in order. Path counts above sixteen are treated as sixteen, and a count of zero
// returns index zero with the no-path flag set. Write hash_seed and select_mode only while
// no item is in flight.
module multipath_hash_selector_top (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [15:0]                           req_source_node,
   input  logic [11:0]                           req_dest_group,
   input  logic [31:0]                           req_flow_number,
   input  logic [31:0]                           req_route_tag,
   input  logic [31:0]                           req_packet_number,
   input  logic [31:0]                           req_round_robin_count,
   input  logic [mhs_pkg::COUNT_WIDTH-1:0]       req_path_count,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [mhs_pkg::INDEX_WIDTH-1:0]       rsp_path_index,
   output logic                                  rsp_no_path,

   input  logic                                  csr_write_enable,
   input  logic [mhs_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [mhs_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   // Operand folded into the hash before each mix of the chain.
   function automatic logic [mhs_pkg::HASH_WIDTH-1:0] chain_operand(
      input int                slot,
      input mhs_pkg::side_type side
   );
      logic [mhs_pkg::HASH_WIDTH-1:0] operand;
      case (slot)
         0:       operand = '0;
         1:       operand = mhs_pkg::CHOICE_TAG;
         2:       operand = 64'(side.source_node);
         3:       operand = 64'(side.dest_group);
         4:       operand = 64'(side.flow_number);
         5:       operand = 64'(side.route_tag);
         6:       operand = 64'(side.packet_number);
         default: operand = '0;
      endcase
      return operand;
   endfunction

   logic [mhs_pkg::HASH_WIDTH-1:0] hash_seed_ff;
   logic [mhs_pkg::MODE_WIDTH-1:0] select_mode_ff;

   logic                          advance;
   logic [mhs_pkg::COUNT_WIDTH-1:0] count_sat;
   mhs_pkg::side_type             entry_side;

   logic                           chain_valid [mhs_pkg::CHAIN_LENGTH+1];
   logic [mhs_pkg::HASH_WIDTH-1:0] chain_hash  [mhs_pkg::CHAIN_LENGTH+1];
   mhs_pkg::side_type              chain_side  [mhs_pkg::CHAIN_LENGTH+1];

   logic [mhs_pkg::HASH_WIDTH-1:0] dividend;

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_seed_ff   <= '0;
         select_mode_ff <= mhs_pkg::MODE_FLOW_HASH;
      end else if (csr_write_enable) begin
         case (csr_index)
            mhs_pkg::CSR_HASH_SEED:   hash_seed_ff   <= csr_write_data;
            mhs_pkg::CSR_SELECT_MODE: select_mode_ff <= csr_write_data[mhs_pkg::MODE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // The whole pipeline moves unless a finished result is waiting.
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // Entry: saturate the path count and prepare the fields for the chain.
   always_comb begin
      if (req_path_count > mhs_pkg::COUNT_WIDTH'(mhs_pkg::MAX_PATHS)) begin
         count_sat = mhs_pkg::COUNT_WIDTH'(mhs_pkg::MAX_PATHS);
      end else begin
         count_sat = req_path_count;
      end
      entry_side.source_node       = req_source_node;
      entry_side.dest_group        = req_dest_group;
      entry_side.flow_number       = req_flow_number;
      entry_side.route_tag         = req_route_tag;
      entry_side.packet_number     = (select_mode_ff == mhs_pkg::MODE_PACKET_HASH)
                                     ? req_packet_number : 32'b0;
      entry_side.round_robin_count = req_round_robin_count;
      entry_side.no_path           = (count_sat == '0);
      entry_side.divisor           = (count_sat == '0) ? mhs_pkg::COUNT_WIDTH'(1) : count_sat;
      entry_side.use_round_robin   = (select_mode_ff == mhs_pkg::MODE_ROUND_ROBIN);
   end

   assign chain_valid[0] = req_valid;
   assign chain_hash[0]  = hash_seed_ff;
   assign chain_side[0]  = entry_side;

   // Seven mix units in a row, each folding in its own operand.
   for (genvar k = 0; k < mhs_pkg::CHAIN_LENGTH; k++) begin : g_chain
      mhs_mix_unit u_mix (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .in_valid   (chain_valid[k]),
         .hash_in    (chain_hash[k]),
         .operand_in (chain_operand(k, chain_side[k])),
         .side_in    (chain_side[k]),
         .out_valid  (chain_valid[k+1]),
         .hash_out   (chain_hash[k+1]),
         .side_out   (chain_side[k+1])
      );
   end

   // Round robin items divide their counter instead of the key.
   assign dividend = chain_side[mhs_pkg::CHAIN_LENGTH].use_round_robin
                     ? {32'b0, chain_side[mhs_pkg::CHAIN_LENGTH].round_robin_count}
                     : chain_hash[mhs_pkg::CHAIN_LENGTH];

   mhs_mod_unit u_mod (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (chain_valid[mhs_pkg::CHAIN_LENGTH]),
      .dividend_in (dividend),
      .side_in     (chain_side[mhs_pkg::CHAIN_LENGTH]),
      .out_valid   (rsp_valid),
      .path_index  (rsp_path_index),
      .no_path     (rsp_no_path)
   );

`ifndef SYNTHESIS
   // A mode write leaves the seed untouched.
   assert property (@(posedge clock) disable iff (reset)
      (csr_write_enable && csr_index == mhs_pkg::CSR_SELECT_MODE) |=> $stable(hash_seed_ff))
      else $error("mode write disturbed the hash seed");
`endif

endmodule

/* dv/multipath_hash_selector_top_test.sv */
// Self-checking testbench for the multipath hash selector: driver, monitor and path predictor.
`timescale 1ns / 1ps

module multipath_hash_selector_top_test;

   // Register index and mode codes that the block is expected to ignore or fold.
   localparam logic [mhs_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED_LOW  = 2'd2;
   localparam logic [mhs_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED_HIGH = 2'd3;
   localparam logic [mhs_pkg::MODE_WIDTH-1:0]      MODE_UNUSED     = 2'd3;

   localparam int RANDOM_PHASES   = 6;
   localparam int PHASE_ITEMS     = 84;
   localparam int DRAIN_CYCLES    = 60;

   // One input item and one selection result, at the port widths.
   typedef struct packed {
      logic [15:0]                     source_node;
      logic [11:0]                     dest_group;
      logic [31:0]                     flow_number;
      logic [31:0]                     route_tag;
      logic [31:0]                     packet_number;
      logic [31:0]                     round_robin_count;
      logic [mhs_pkg::COUNT_WIDTH-1:0] path_count;
   } route_request_type;

   typedef struct packed {
      logic [mhs_pkg::INDEX_WIDTH-1:0] path_index;
      logic                            no_path;
   } path_choice_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   route_request_type req_item = '0;

   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [mhs_pkg::INDEX_WIDTH-1:0] rsp_path_index;
   logic                            rsp_no_path;

   logic                                csr_write_enable = 1'b0;
   logic [mhs_pkg::CSR_INDEX_WIDTH-1:0] csr_index = mhs_pkg::CSR_HASH_SEED;
   logic [mhs_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   // Local copy of the selector's registers, at their reset values.
   logic [63:0]                    cfg_hash_seed   = '0;
   logic [mhs_pkg::MODE_WIDTH-1:0] cfg_select_mode = mhs_pkg::MODE_FLOW_HASH;

   route_request_type pending_requests[$];
   path_choice_type   expected_choices[$];

   logic req_fire_ff = 1'b0;
   int   sender_idle_pct    = 0;
   int   receiver_stall_pct = 0;
   int   items_queued       = 0;
   int   items_accepted     = 0;
   int   results_checked    = 0;
   int   no_path_results    = 0;
   int   mismatch_count     = 0;
   int   settings_used      = 1;
   int   mode_items[4]      = '{0, 0, 0, 0};

   multipath_hash_selector_top uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_source_node       (req_item.source_node),
      .req_dest_group        (req_item.dest_group),
      .req_flow_number       (req_item.flow_number),
      .req_route_tag         (req_item.route_tag),
      .req_packet_number     (req_item.packet_number),
      .req_round_robin_count (req_item.round_robin_count),
      .req_path_count        (req_item.path_count),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_path_index        (rsp_path_index),
      .rsp_no_path           (rsp_no_path),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   always #5 clock = ~clock;

   // One splitmix64 finalizer round.
   function automatic logic [63:0] splitmix_round(input logic [63:0] value);
      logic [63:0] v;
      v = value + mhs_pkg::GOLDEN_INC;
      v = (v ^ (v >> 30)) * mhs_pkg::MIX_MUL_A;
      v = (v ^ (v >> 27)) * mhs_pkg::MIX_MUL_B;
      return v ^ (v >> 31);
   endfunction

   // Seven chained rounds over the seed, the choice tag and the item's ids.
   function automatic logic [63:0] hash_chain_key(input route_request_type r,
                                                  input logic [31:0] pkt_value);
      logic [63:0] h;
      h = splitmix_round(cfg_hash_seed);
      h = splitmix_round(h ^ mhs_pkg::CHOICE_TAG);
      h = splitmix_round(h ^ {48'd0, r.source_node});
      h = splitmix_round(h ^ {52'd0, r.dest_group});
      h = splitmix_round(h ^ {32'd0, r.flow_number});
      h = splitmix_round(h ^ {32'd0, r.route_tag});
      h = splitmix_round(h ^ {32'd0, pkt_value});
      return h;
   endfunction

   // Path choice for one item under the current register settings.
   function automatic path_choice_type predict_choice(input route_request_type r);
      logic [mhs_pkg::COUNT_WIDTH-1:0] paths;
      logic [63:0]                     key;
      path_choice_type                 choice;
      paths = (r.path_count > mhs_pkg::MAX_PATHS) ?
              mhs_pkg::COUNT_WIDTH'(mhs_pkg::MAX_PATHS) : r.path_count;
      choice = '0;
      if (paths == 0) begin
         choice.no_path = 1'b1;
      end else if (cfg_select_mode == mhs_pkg::MODE_ROUND_ROBIN) begin
         choice.path_index = mhs_pkg::INDEX_WIDTH'(r.round_robin_count % {27'd0, paths});
      end else begin
         // Per-flow hash, and the unused mode code, hash with a zero packet id.
         key = hash_chain_key(r, (cfg_select_mode == mhs_pkg::MODE_PACKET_HASH) ?
                                 r.packet_number : 32'd0);
         choice.path_index = mhs_pkg::INDEX_WIDTH'(key % {59'd0, paths});
      end
      return choice;
   endfunction

   function automatic route_request_type make_request(
      input logic [15:0]                     source_node,
      input logic [11:0]                     dest_group,
      input logic [31:0]                     flow_number,
      input logic [31:0]                     route_tag,
      input logic [31:0]                     packet_number,
      input logic [31:0]                     round_robin_count,
      input logic [mhs_pkg::COUNT_WIDTH-1:0] paths
   );
      route_request_type r;
      r.source_node       = source_node;
      r.dest_group        = dest_group;
      r.flow_number       = flow_number;
      r.route_tag         = route_tag;
      r.packet_number     = packet_number;
      r.round_robin_count = round_robin_count;
      r.path_count        = paths;
      return r;
   endfunction

   // Random item: mostly legal path counts, with some empty and oversized tables.
   function automatic route_request_type random_request();
      route_request_type r;
      int                pick;
      r.source_node       = 16'($urandom);
      r.dest_group        = 12'($urandom);
      r.flow_number       = $urandom;
      r.route_tag         = $urandom;
      r.packet_number     = $urandom;
      r.round_robin_count = $urandom;
      pick = $urandom_range(99);
      if (pick < 8) begin
         r.path_count = '0;
      end else if (pick < 16) begin
         r.path_count = mhs_pkg::COUNT_WIDTH'($urandom_range(31, mhs_pkg::MAX_PATHS + 1));
      end else begin
         r.path_count = mhs_pkg::COUNT_WIDTH'($urandom_range(mhs_pkg::MAX_PATHS, 1));
      end
      return r;
   endfunction

   task automatic queue_request(input route_request_type r);
      pending_requests.insert(pending_requests.size(), r);
      items_queued++;
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // Single register write; the local copy follows the block's decode.
   task automatic write_csr(input logic [mhs_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [mhs_pkg::CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (index == mhs_pkg::CSR_HASH_SEED) begin
         cfg_hash_seed = data;
      end else if (index == mhs_pkg::CSR_SELECT_MODE) begin
         cfg_select_mode = data[mhs_pkg::MODE_WIDTH-1:0];
      end
   endtask

   // Block until every queued item has been taken and its result checked.
   task automatic wait_until_drained();
      while (items_accepted != items_queued || expected_choices.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Request driver and result-side ready, both moved on the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_fire_ff) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_item  <= pending_requests.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Monitor: predict on each accepted item, check each accepted result in order.
   always @(posedge clock) begin
      path_choice_type want;
      if (reset) begin
         req_fire_ff <= 1'b0;
      end else begin
         req_fire_ff <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            expected_choices.insert(expected_choices.size(), predict_choice(req_item));
            items_accepted++;
            mode_items[cfg_select_mode]++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_choices.size() == 0) begin
               report_mismatch($sformatf("result index %0d no_path %0b with nothing expected",
                                         rsp_path_index, rsp_no_path));
            end else begin
               want = expected_choices.pop_front();
               results_checked++;
               if (want.no_path) no_path_results++;
               if (rsp_path_index !== want.path_index) begin
                  report_mismatch($sformatf("result %0d: path_index %0d, expected %0d",
                                            results_checked, rsp_path_index, want.path_index));
               end
               if (rsp_no_path !== want.no_path) begin
                  report_mismatch($sformatf("result %0d: no_path %0b, expected %0b",
                                            results_checked, rsp_no_path, want.no_path));
               end
            end
         end
      end
   end

   // Stimulus: directed items per register setting, then random phases.
   initial begin
      logic [63:0]                    seed;
      logic [63:0]                    junk;
      logic [mhs_pkg::MODE_WIDTH-1:0] mode;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings (zero seed, per-flow hash): empty, single, full and oversized tables.
      sender_idle_pct    = 25;
      receiver_stall_pct = 73;
      queue_request(make_request('0, '0, '0, '0, '0, '0, 5'd0));
      queue_request(make_request('0, '0, '0, '0, '0, '0, 5'd1));
      queue_request(make_request('1, '1, '1, '1, '1, '1, 5'd16));
      queue_request(make_request('1, '1, '1, '1, '1, '1, 5'd31));
      queue_request(make_request(16'h8001, 12'h801, 32'h8000_0001, 32'h7fff_fffe,
                                 32'h1234_5678, 32'h0, 5'd17));
      queue_request(make_request(16'h00ff, 12'h0f0, 32'hdead_beef, 32'h0bad_f00d,
                                 32'h0, 32'h5, 5'd5));
      wait_until_drained();

      // Round robin, selected by a write whose upper data bits are all set.
      write_csr(mhs_pkg::CSR_SELECT_MODE, 64'hffff_ffff_ffff_fffc);
      write_csr(CSR_UNUSED_LOW, '1);
      write_csr(CSR_UNUSED_HIGH, 64'h5555_aaaa_5555_aaaa);
      settings_used++;
      queue_request(make_request('0, '0, '0, '0, '0, 32'd0, 5'd16));
      queue_request(make_request('0, '0, '0, '0, '0, '1, 5'd16));
      queue_request(make_request('0, '0, '0, '0, '0, '1, 5'd31));
      queue_request(make_request('1, '1, '1, '1, '1, 32'd100, 5'd3));
      queue_request(make_request('0, '0, '0, '0, '0, '1, 5'd0));
      queue_request(make_request('0, '0, '0, '0, '0, 32'd7, 5'd1));
      wait_until_drained();

      // Per-packet hash with an all-ones seed: packet id extremes.
      write_csr(mhs_pkg::CSR_HASH_SEED, '1);
      write_csr(mhs_pkg::CSR_SELECT_MODE, {62'd0, mhs_pkg::MODE_PACKET_HASH});
      settings_used++;
      queue_request(make_request(16'h1234, 12'h345, 32'h1, 32'h2, '0, '0, 5'd16));
      queue_request(make_request(16'h1234, 12'h345, 32'h1, 32'h2, '1, '0, 5'd16));
      queue_request(make_request('1, '1, '1, '1, '1, '1, 5'd16));
      queue_request(make_request('1, '1, '1, '1, '1, '1, 5'd0));
      queue_request(make_request('0, '0, '0, '0, 32'h8000_0000, '0, 5'd7));
      wait_until_drained();

      // Unused mode code acts as per-flow hash, so the packet id must not matter.
      write_csr(mhs_pkg::CSR_SELECT_MODE, '1);
      write_csr(mhs_pkg::CSR_HASH_SEED, 64'h8000_0000_0000_0001);
      settings_used++;
      queue_request(make_request(16'h4321, 12'habc, 32'hcafe_f00d, 32'h3, 32'h0, '0, 5'd11));
      queue_request(make_request(16'h4321, 12'habc, 32'hcafe_f00d, 32'h3, '1, '0, 5'd11));
      queue_request(make_request('1, '1, '1, '1, '1, '1, 5'd31));
      wait_until_drained();

      // Random phases: each with fresh settings; each pair of phases shares an idling pattern.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 4)
            0:       mode = mhs_pkg::MODE_ROUND_ROBIN;
            1:       mode = mhs_pkg::MODE_PACKET_HASH;
            2:       mode = mhs_pkg::MODE_FLOW_HASH;
            default: mode = MODE_UNUSED;
         endcase
         seed = {$urandom, $urandom};
         junk = {$urandom, $urandom};
         write_csr(mhs_pkg::CSR_HASH_SEED, seed);
         write_csr(mhs_pkg::CSR_SELECT_MODE, {junk[63:mhs_pkg::MODE_WIDTH], mode});
         write_csr((p % 2 == 0) ? CSR_UNUSED_LOW : CSR_UNUSED_HIGH, {$urandom, $urandom});
         settings_used++;
         if (p < 2) begin
            sender_idle_pct    = 25;
            receiver_stall_pct = 73;
         end else if (p < 4) begin
            sender_idle_pct    = 73;
            receiver_stall_pct = 25;
         end else begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            queue_request(random_request());
         end
         wait_until_drained();
      end

      // Keep watching for stray results for longer than the pipeline latency.
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d items over %0d register settings: %0d round robin, %0d packet hash,",
               items_accepted, settings_used, mode_items[mhs_pkg::MODE_ROUND_ROBIN],
               mode_items[mhs_pkg::MODE_PACKET_HASH]);
      $display("%0d flow hash, %0d unused mode code; %0d results compared, %0d with no path.",
               mode_items[mhs_pkg::MODE_FLOW_HASH], mode_items[MODE_UNUSED], results_checked,
               no_path_results);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("Timeout: %0d of %0d items accepted, %0d results outstanding",
               items_accepted, items_queued, expected_choices.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* files.f */
sv/mhs_pkg.sv
sv/mhs_mix_unit.sv
sv/mhs_mod_unit.sv
sv/multipath_hash_selector_top.sv
dv/multipath_hash_selector_top_test.sv
